// ===== rtl/qst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qst_pkg - shared constants and types of the smallest-three quaternion codec
// fixed-point formats, derived datapath widths, operation codes and the
// record that travels beside the radicand through the square-root pipeline
// ----------------------------------------------------------------------------
package qst_pkg;

	// component format and code scale
	localparam int FRAC_BITS  = 14;
	localparam int CODE_SCALE = 1000;

	// field widths
	localparam int COMP_W = 16;
	localparam int CODE_W = 11;
	localparam int IDX_W  = 2;
	localparam int NCOMP  = 4;
	localparam int NKEEP  = 3;

	// stream word widths, whole bytes
	localparam int IN_BITS  = NCOMP*COMP_W + NKEEP*CODE_W + IDX_W;
	localparam int OUT_BITS = NCOMP*COMP_W + NKEEP*CODE_W + IDX_W + 1;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// field offsets inside tdata
	localparam int CODE_OFS = NCOMP*COMP_W;
	localparam int IDX_OFS  = CODE_OFS + NKEEP*CODE_W;
	localparam int FLAG_OFS = IDX_OFS + IDX_W;

	// pack path: magnitude-extended component times scale
	localparam int CS_W    = $clog2(CODE_SCALE + 1);
	localparam int MAG_W   = COMP_W + 1;
	localparam int PP_BASE = MAG_W + CS_W + 1;
	localparam int PP_W    = (PP_BASE > FRAC_BITS + 1) ? PP_BASE : FRAC_BITS + 2;

	// unpack path: code offset, magnitude and reciprocal divide
	localparam int CODE_MAX = (1 << CODE_W) - 1;
	localparam int MK_MAX   = (CODE_SCALE > CODE_MAX - CODE_SCALE) ?
		CODE_SCALE : CODE_MAX - CODE_SCALE;
	localparam int MK_W     = $clog2(MK_MAX + 1);
	localparam int KW       = ((CODE_W > CS_W) ? CODE_W : CS_W) + 1;
	localparam logic [63:0] RECIP  = (64'd1 << (FRAC_BITS + MK_W)) / 64'(CODE_SCALE);
	localparam int R_W      = $clog2(RECIP + 64'd1);
	localparam logic [63:0] MV_MAX = (64'(MK_MAX) << FRAC_BITS) / 64'(CODE_SCALE);
	localparam int MV_W     = $clog2(MV_MAX + 64'd1);
	localparam int UP_W     = MK_W + R_W;
	localparam int NUM_W    = MK_W + FRAC_BITS;
	localparam int SQ_W     = 2 * MV_W;
	localparam int SUM_W    = SQ_W + 2;

	// square root
	localparam int RAD_W  = 2*FRAC_BITS + 1;
	localparam int ROOT_W = FRAC_BITS + 1;

	typedef enum logic {
		MODE_PACK   = 1'b0,
		MODE_UNPACK = 1'b1
	} mode_t;

	// side record carried along the root pipeline
	typedef struct packed {
		mode_t                            mode;
		logic [IDX_W-1:0]                 idx;
		logic [NKEEP-1:0][CODE_W-1:0]     code;
		logic [NKEEP-1:0][COMP_W-1:0]     val;
		logic                             clamped;
	} info_t;

endpackage
`default_nettype wire

// ===== rtl/qst_root_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qst_root_pipe - pipelined integer square root
// digit-by-digit restoring root, two result bits per stage (one in the last),
// with a side record and per-stage valid and backpressure
// ----------------------------------------------------------------------------
module qst_root_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [qst_pkg::RAD_W-1:0]     in_rad,
	input  qst_pkg::info_t                in_info,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [qst_pkg::ROOT_W-1:0]    out_root,
	output qst_pkg::info_t                out_info
);
	import qst_pkg::*;

	localparam int NST = (ROOT_W + 1) / 2;
	localparam int T_W = RAD_W + 2;
	localparam int SR_W = RAD_W + ROOT_W;

	// one root bit: keep it when the remainder covers (root + 2^b)^2 - root^2
	function automatic logic [SR_W-1:0] sqrt_step(input logic [RAD_W-1:0] rem,
			input logic [ROOT_W-1:0] root, input int bitpos);
		logic [T_W-1:0] trial;
		logic [T_W-1:0] remx;
		trial = (T_W'(root) << (bitpos + 1)) + (T_W'(1) << (2 * bitpos));
		remx  = T_W'(rem);
		if (remx >= trial)
			return {RAD_W'(remx - trial), root | (ROOT_W'(1) << bitpos)};
		else
			return {rem, root};
	endfunction

	logic                vld_sn  [NST];
	logic [RAD_W-1:0]    rem_sn  [NST];
	logic [ROOT_W-1:0]   root_sn [NST];
	info_t               info_sn [NST];
	logic                adv     [NST+1];

	assign adv[NST] = out_ready;
	assign in_ready = adv[0];

	genvar k;
	generate
		for (k = 0; k < NST; k++) begin : g_st
			localparam int B0 = ROOT_W - 1 - 2*k;
			logic              vin;
			logic [RAD_W-1:0]  rem_in;
			logic [ROOT_W-1:0] root_in;
			info_t             info_in;
			logic [SR_W-1:0]   st_a;
			logic [SR_W-1:0]   st_b;

			if (k == 0) begin : g_head
				assign vin     = in_valid;
				assign rem_in  = in_rad;
				assign root_in = '0;
				assign info_in = in_info;
			end else begin : g_body
				assign vin     = vld_sn[k-1];
				assign rem_in  = rem_sn[k-1];
				assign root_in = root_sn[k-1];
				assign info_in = info_sn[k-1];
			end

			assign st_a = sqrt_step(rem_in, root_in, B0);
			if (B0 >= 1) begin : g_two
				assign st_b = sqrt_step(st_a[SR_W-1:ROOT_W], st_a[ROOT_W-1:0], B0 - 1);
			end else begin : g_one
				assign st_b = st_a;
			end

			assign adv[k] = !vld_sn[k] || adv[k+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_sn[k] <= 1'b0;
				else if (adv[k])
					vld_sn[k] <= vin;
			end

			always_ff @(posedge clk) begin
				if (adv[k]) begin
					rem_sn[k]  <= st_b[SR_W-1:ROOT_W];
					root_sn[k] <= st_b[ROOT_W-1:0];
					info_sn[k] <= info_in;
				end
			end
		end
	endgenerate

	assign out_valid = vld_sn[NST-1];
	assign out_root  = root_sn[NST-1];
	assign out_info  = info_sn[NST-1];

endmodule
`default_nettype wire

// ===== rtl/quaternion_smallest_three_codec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_smallest_three_codec - smallest-three rotation quaternion codec
// packs a Q2.14 quaternion to three kept-component codes and the dropped
// index, or unpacks codes back to four components with a rebuilt root term
// ----------------------------------------------------------------------------
// usage:
//   input channel s_axis: one item per transfer, tuser[0] selects the
//   operation (0 pack, 1 unpack); tdata carries the quaternion components
//   (used by pack) and the three codes with the dropped index (used by
//   unpack). output channel m_axis: one result per input item, in order.
//   pipeline: from input transfer to output transfer an item passes the
//   front stages and then the square-root stages. the square root takes two
//   result bits per stage, one in its last, and sets the depth; the five
//   front stages hold the magnitude search, the scale multiplies, the
//   reciprocal divide, the squares and the radicand sum.
//   throughput: one item per cycle unless m_axis_tready stalls the line;
//   every stage carries its own valid bit, so an item can enter each cycle
//   and a new transfer is accepted whenever any stage down the line has room.
//   stall: while m_axis_tready is low the output holds its result, the
//   stages behind it fill up and s_axis_tready drops only once every stage
//   holds an item; nothing is dropped or repeated.
//   reset: arst_n clears all valid bits; the pipeline comes up empty and
//   ready, no result is pending.
// ----------------------------------------------------------------------------
module quaternion_smallest_three_codec (
	input  logic                       clk,
	input  logic                       arst_n,
	// input: comp_x, comp_y, comp_z, comp_w, code_first, code_second,
	// code_third, dropped_index, zero fill
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [qst_pkg::IN_W-1:0]   s_axis_tdata,
	// input: mode
	input  logic [0:0]                 s_axis_tuser,
	// output: out_x, out_y, out_z, out_w, out_code_first, out_code_second,
	// out_code_third, out_index, root_clamped, zero fill
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [qst_pkg::OUT_W-1:0]  m_axis_tdata
);
	import qst_pkg::*;

	localparam logic signed [PP_W-1:0] CS_P        = PP_W'(CODE_SCALE);
	localparam logic signed [PP_W-1:0] FRAC_MASK_P = (PP_W'(1) << FRAC_BITS) - PP_W'(1);
	localparam logic signed [KW-1:0]   CS_K        = KW'(CODE_SCALE);
	localparam logic [R_W-1:0]         RECIP_C     = R_W'(RECIP);
	localparam logic [SUM_W-1:0]       ONE_SUM     = SUM_W'(1) << (2 * FRAC_BITS);

	// stage handshake: a stage loads when it is empty or the next one moves
	logic adv1, adv2, adv3, adv4, adv5;
	logic root_ready;

	// ------------------------------------------------------------------ s1
	// pack: magnitudes and first-wins largest search
	// unpack: code to signed thousandths, magnitude times reciprocal
	logic signed [COMP_W-1:0] comp_in [NCOMP];
	logic [MAG_W-1:0]         mag     [NCOMP];
	logic [IDX_W-1:0]         big_idx;
	logic [MAG_W-1:0]         big_mag;
	logic [CODE_W-1:0]        code_in [NKEEP];
	logic signed [KW-1:0]     k_in    [NKEEP];
	logic [MK_W-1:0]          mk_in   [NKEEP];
	mode_t                    mode_in;

	logic                     vld_s1;
	mode_t                    mode_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic signed [COMP_W-1:0] comp_s1  [NCOMP];
	logic [UP_W-1:0]          uprod_s1 [NKEEP];
	logic [MK_W-1:0]          mk_s1    [NKEEP];
	logic                     uneg_s1  [NKEEP];

	assign mode_in = mode_t'(s_axis_tuser[0]);

	always_comb begin
		logic signed [MAG_W-1:0] cx;
		for (int j = 0; j < NCOMP; j++) begin
			comp_in[j] = s_axis_tdata[j*COMP_W +: COMP_W];
			cx         = MAG_W'(comp_in[j]);
			mag[j]     = cx[MAG_W-1] ? MAG_W'(-cx) : MAG_W'(cx);
		end
		big_idx = '0;
		big_mag = mag[0];
		for (int j = 1; j < NCOMP; j++) begin
			if (mag[j] > big_mag) begin
				big_mag = mag[j];
				big_idx = IDX_W'(j);
			end
		end
		for (int j = 0; j < NKEEP; j++) begin
			code_in[j] = s_axis_tdata[CODE_OFS + j*CODE_W +: CODE_W];
			k_in[j]    = $signed(KW'(code_in[j])) - CS_K;
			mk_in[j]   = k_in[j][KW-1] ? MK_W'(-k_in[j]) : MK_W'(k_in[j]);
		end
	end

	assign adv1 = !vld_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv1)
			vld_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			mode_s1 <= mode_in;
			idx_s1  <= (mode_in == MODE_UNPACK) ? s_axis_tdata[IDX_OFS +: IDX_W] : big_idx;
			for (int j = 0; j < NCOMP; j++)
				comp_s1[j] <= comp_in[j];
			for (int j = 0; j < NKEEP; j++) begin
				uprod_s1[j] <= UP_W'(mk_in[j]) * UP_W'(RECIP_C);
				mk_s1[j]    <= mk_in[j];
				uneg_s1[j]  <= k_in[j][KW-1];
			end
		end
	end

	// ------------------------------------------------------------------ s2
	// pack: sign fold on the dominant component, kept ones times scale
	// unpack: quotient estimate and its product with the scale
	logic                     fold;
	logic signed [COMP_W-1:0] kept [NKEEP];
	logic [MV_W-1:0]          q0   [NKEEP];

	logic                     vld_s2;
	mode_t                    mode_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic signed [PP_W-1:0]   pprod_s2 [NKEEP];
	logic [MV_W-1:0]          q0_s2    [NKEEP];
	logic [NUM_W-1:0]         qs_s2    [NKEEP];
	logic [MK_W-1:0]          mk_s2    [NKEEP];
	logic                     uneg_s2  [NKEEP];

	always_comb begin
		case (idx_s1)
			2'd0:    fold = comp_s1[0][COMP_W-1];
			2'd1:    fold = comp_s1[1][COMP_W-1];
			2'd2:    fold = comp_s1[2][COMP_W-1];
			default: fold = comp_s1[3][COMP_W-1];
		endcase
		// kept components in ascending index order, dominant one skipped
		kept[0] = (idx_s1 == 2'd0) ? comp_s1[1] : comp_s1[0];
		kept[1] = (idx_s1 <= 2'd1) ? comp_s1[2] : comp_s1[1];
		kept[2] = (idx_s1 <= 2'd2) ? comp_s1[3] : comp_s1[2];
		for (int j = 0; j < NKEEP; j++)
			q0[j] = MV_W'(uprod_s1[j] >> MK_W);
	end

	assign adv2 = !vld_s2 || adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv2)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		logic signed [PP_W-1:0] vx;
		if (adv2) begin
			mode_s2 <= mode_s1;
			idx_s2  <= idx_s1;
			for (int j = 0; j < NKEEP; j++) begin
				vx = fold ? -PP_W'(kept[j]) : PP_W'(kept[j]);
				pprod_s2[j] <= vx * CS_P;
				q0_s2[j]    <= q0[j];
				qs_s2[j]    <= NUM_W'(q0[j]) * NUM_W'(CODE_SCALE);
				mk_s2[j]    <= mk_s1[j];
				uneg_s2[j]  <= uneg_s1[j];
			end
		end
	end

	// ------------------------------------------------------------------ s3
	// pack: divide by 2^FRAC_BITS toward zero, clamp, offset
	// unpack: one correction step finishes the floor divide by the scale
	logic signed [PP_W-1:0] biased [NKEEP];
	logic signed [PP_W-1:0] kq     [NKEEP];
	logic [NUM_W-1:0]       rem    [NKEEP];

	logic                   vld_s3;
	mode_t                  mode_s3;
	logic [IDX_W-1:0]       idx_s3;
	logic [CODE_W-1:0]      code_s3 [NKEEP];
	logic [MV_W-1:0]        mv_s3   [NKEEP];
	logic                   uneg_s3 [NKEEP];

	always_comb begin
		for (int j = 0; j < NKEEP; j++) begin
			biased[j] = pprod_s2[j] + (pprod_s2[j][PP_W-1] ? FRAC_MASK_P : PP_W'(0));
			kq[j]     = biased[j] >>> FRAC_BITS;
			if (kq[j] > CS_P)
				kq[j] = CS_P;
			else if (kq[j] < -CS_P)
				kq[j] = -CS_P;
			rem[j]    = (NUM_W'(mk_s2[j]) << FRAC_BITS) - qs_s2[j];
		end
	end

	assign adv3 = !vld_s3 || adv4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (adv3)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			mode_s3 <= mode_s2;
			idx_s3  <= idx_s2;
			for (int j = 0; j < NKEEP; j++) begin
				code_s3[j] <= CODE_W'(kq[j] + CS_P);
				mv_s3[j]   <= q0_s2[j] + MV_W'(rem[j] >= NUM_W'(CODE_SCALE));
				uneg_s3[j] <= uneg_s2[j];
			end
		end
	end

	// ------------------------------------------------------------------ s4
	// unpack: squares of the kept magnitudes, signed kept values
	logic                   vld_s4;
	mode_t                  mode_s4;
	logic [IDX_W-1:0]       idx_s4;
	logic [CODE_W-1:0]      code_s4 [NKEEP];
	logic [SQ_W-1:0]        sq_s4   [NKEEP];
	logic [COMP_W-1:0]      val_s4  [NKEEP];

	assign adv4 = !vld_s4 || adv5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (adv4)
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			mode_s4 <= mode_s3;
			idx_s4  <= idx_s3;
			for (int j = 0; j < NKEEP; j++) begin
				code_s4[j] <= code_s3[j];
				sq_s4[j]   <= SQ_W'(mv_s3[j]) * SQ_W'(mv_s3[j]);
				val_s4[j]  <= uneg_s3[j] ? -COMP_W'(mv_s3[j]) : COMP_W'(mv_s3[j]);
			end
		end
	end

	// ------------------------------------------------------------------ s5
	// radicand = one minus sum of squares; negative clamps to zero and flags.
	// pack items get a zero radicand and zero values so the unpack fields
	// of their result come out zero
	logic [SUM_W-1:0]  sum_sq;
	logic              over;
	logic              is_unpack4;

	logic              vld_s5;
	logic [RAD_W-1:0]  rad_s5;
	info_t             info_s5;

	assign sum_sq     = SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
	assign over       = sum_sq > ONE_SUM;
	assign is_unpack4 = (mode_s4 == MODE_UNPACK);

	assign adv5 = !vld_s5 || root_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else if (adv5)
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			rad_s5          <= (is_unpack4 && !over) ? RAD_W'(ONE_SUM - sum_sq) : '0;
			info_s5.mode    <= mode_s4;
			info_s5.idx     <= idx_s4;
			info_s5.clamped <= is_unpack4 && over;
			for (int j = 0; j < NKEEP; j++) begin
				info_s5.code[j] <= is_unpack4 ? '0 : code_s4[j];
				info_s5.val[j]  <= is_unpack4 ? val_s4[j] : '0;
			end
		end
	end

	// ------------------------------------------------------- root stages
	logic [ROOT_W-1:0] root_out;
	info_t             info_out;

	qst_root_pipe u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.in_ready  (root_ready),
		.in_rad    (rad_s5),
		.in_info   (info_s5),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_root  (root_out),
		.out_info  (info_out)
	);

	// ------------------------------------------------------- result word
	// rebuilt component goes to the dropped slot, kept values fill the rest
	logic [COMP_W-1:0] root16;
	logic [COMP_W-1:0] out_comp [NCOMP];
	logic [IDX_W-1:0]  oidx;

	assign root16 = COMP_W'(root_out);
	assign oidx   = info_out.idx;

	always_comb begin
		out_comp[0] = (oidx == 2'd0) ? root16 : info_out.val[0];
		out_comp[1] = (oidx == 2'd1) ? root16 :
			((oidx == 2'd0) ? info_out.val[0] : info_out.val[1]);
		out_comp[2] = (oidx == 2'd2) ? root16 :
			((oidx == 2'd3) ? info_out.val[2] : info_out.val[1]);
		out_comp[3] = (oidx == 2'd3) ? root16 : info_out.val[2];
	end

	assign m_axis_tdata = {
		(OUT_W - OUT_BITS)'(0),
		info_out.clamped,
		oidx,
		info_out.code[2], info_out.code[1], info_out.code[0],
		out_comp[3], out_comp[2], out_comp[1], out_comp[0]
	};

	// ------------------------------------------------------- assertions
	// pack results never carry rebuilt components or a clamp flag
	a_pack_no_unpack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && info_out.mode == MODE_PACK) |->
		(m_axis_tdata[CODE_OFS-1:0] == '0 && !info_out.clamped))
		else $error("pack result carries unpack fields");

	// unpack results never carry codes
	a_unpack_no_codes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && info_out.mode == MODE_UNPACK) |->
		(info_out.code == '0))
		else $error("unpack result carries codes");

	// pack codes stay inside the clamp window
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && info_out.mode == MODE_PACK && 2*CODE_SCALE <= CODE_MAX) |->
		(int'(info_out.code[0]) <= 2*CODE_SCALE && int'(info_out.code[1]) <= 2*CODE_SCALE
		&& int'(info_out.code[2]) <= 2*CODE_SCALE))
		else $error("pack code outside clamp window");

	// a clamped radicand rebuilds the dropped component as zero
	a_clamp_zero_root: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && info_out.clamped) |-> (root_out == '0))
		else $error("clamped radicand gave nonzero root");

	// the root never exceeds one in the component format
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (root_out <= (ROOT_W'(1) << FRAC_BITS)))
		else $error("root above unity");

endmodule
`default_nettype wire
